// File: rtl/kpsd_pkg.sv
`timescale 1ns / 1ps

package kpsd_pkg;

    // Number of digit slots kept in the entry register (1 to 8).
    localparam int NUM_DIGITS = 4;
    // Number of digits shown on the packed display word.
    localparam int SHOWN_DIGITS = 4;

    localparam int COL_W = 2;
    localparam int ROW_W = 2;
    localparam int TICK_W = 16;
    localparam int CODE_W = 4;
    localparam int LINES = 4;
    localparam int DISPLAY_W = CODE_W * SHOWN_DIGITS;

    localparam logic [TICK_W-1:0] SETTLE_RESET = TICK_W'(50);
    localparam logic [CODE_W-1:0] KEY_CLEAR = CODE_W'(10);

    typedef logic [CODE_W-1:0] key_code_t;
    typedef key_code_t [NUM_DIGITS-1:0] digit_array_t;

    // Decoded key for a column and row position.
    function automatic key_code_t key_lookup(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        key_code_t code;
        code = KEY_CLEAR;
        unique case (col)
            2'd0: code = KEY_CLEAR;
            2'd1:
            begin
                unique case (row)
                    2'd0: code = KEY_CLEAR;
                    2'd1: code = CODE_W'(3);
                    2'd2: code = CODE_W'(6);
                    default: code = CODE_W'(9);
                endcase
            end
            2'd2:
            begin
                unique case (row)
                    2'd0: code = CODE_W'(0);
                    2'd1: code = CODE_W'(2);
                    2'd2: code = CODE_W'(5);
                    default: code = CODE_W'(8);
                endcase
            end
            default:
            begin
                unique case (row)
                    2'd0: code = KEY_CLEAR;
                    2'd1: code = CODE_W'(1);
                    2'd2: code = CODE_W'(4);
                    default: code = CODE_W'(7);
                endcase
            end
        endcase
        return code;
    endfunction

endpackage

// File: rtl/kpsd_if.sv
`timescale 1ns / 1ps

// Row sample channel.
interface kpsd_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_levels;

    modport source (output valid, output row_levels, input ready);
    modport sink (input valid, input row_levels, output ready);
endinterface

// Result channel.
interface kpsd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  column_drive;
    logic [15:0] display_digits;
    logic        key_event;
    logic [3:0]  key_code;

    modport source (output valid, output column_drive, output display_digits,
                    output key_event, output key_code, input ready);
    modport sink (input valid, input column_drive, input display_digits,
                  input key_event, input key_code, output ready);
endinterface

// Settle time register write channel.
interface kpsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] settle_ticks;

    modport source (output valid, output settle_ticks, input ready);
    modport sink (input valid, input settle_ticks, output ready);
endinterface

// File: rtl/keypad_scan_digit_entry_core.sv
`timescale 1ns / 1ps

// Channel   Role    Payload
// samples   sink    row_levels (4 bits, low = pressed)
// results   source  column_drive, display_digits, key_event, key_code
// cfg       sink    settle_ticks (16 bits, written while idle)
//
// One sample is taken per cycle while the output register can take it; its
// result is ready in the output register on the following cycle, set by the
// single pass of scan update logic. A new sample is taken while a result
// waits, as long as the output register is empty or is being drained in the
// same cycle. Reset puts settle_ticks at 50, column 0, row 0, settling
// started and all digits zero. The cfg channel is always ready.

module keypad_scan_digit_entry_core
(
    input logic clk,
    input logic rst_n,
    kpsd_in_if.sink samples,
    kpsd_out_if.source results,
    kpsd_cfg_if.sink cfg
);
    import kpsd_pkg::*;

    // Scan state.
    logic [TICK_W-1:0] settle_ticks_reg;
    logic [COL_W-1:0]  column_index_reg, column_index_next;
    logic [TICK_W-1:0] settle_count_reg, settle_count_next;
    logic [ROW_W-1:0]  row_pointer_reg, row_pointer_next;
    logic              wait_release_reg, wait_release_next;
    digit_array_t      digits_reg, digits_next;

    // Output register.
    logic                 out_valid_reg;
    logic [LINES-1:0]     out_column_reg, out_column_next;
    logic [DISPLAY_W-1:0] out_display_reg, out_display_next;
    logic                 out_event_reg, out_event_next;
    key_code_t            out_code_reg, out_code_next;

    logic      sample_xfer;
    logic      pressed;
    logic      settling;
    key_code_t key;

    // The output register frees up when it is empty or being drained.
    assign samples.ready = !out_valid_reg || results.ready;
    assign sample_xfer = samples.valid && samples.ready;
    assign cfg.ready = 1'b1;

    assign settling = settle_count_reg < settle_ticks_reg;
    assign pressed = !samples.row_levels[row_pointer_reg];
    assign key = key_lookup(column_index_reg, row_pointer_reg);

    always_comb
    begin
        column_index_next = column_index_reg;
        settle_count_next = settle_count_reg;
        row_pointer_next = row_pointer_reg;
        wait_release_next = wait_release_reg;
        digits_next = digits_reg;
        out_event_next = 1'b0;
        out_code_next = '0;

        priority if (settling)
        begin
            settle_count_next = settle_count_reg + TICK_W'(1);
        end
        else if (wait_release_reg || !pressed)
        begin
            // A held key waits here; once its row reads high again, or when
            // the row is simply not pressed, the scan moves one row on.
            if (!pressed)
            begin
                wait_release_next = 1'b0;
                if (row_pointer_reg == ROW_W'(LINES - 1))
                begin
                    row_pointer_next = '0;
                    column_index_next = column_index_reg + COL_W'(1);
                    settle_count_next = '0;
                end
                else
                begin
                    row_pointer_next = row_pointer_reg + ROW_W'(1);
                end
            end
        end
        else
        begin
            // New press: register the key and hold the row until release.
            out_event_next = 1'b1;
            out_code_next = key;
            wait_release_next = 1'b1;
            if (key == KEY_CLEAR)
            begin
                digits_next = '0;
            end
            else
            begin
                for (int i = NUM_DIGITS - 1; i > 0; i--)
                begin
                    digits_next[i] = digits_reg[i - 1];
                end
                digits_next[0] = key;
            end
        end

        out_column_next = ~(LINES'(1) << column_index_next);
        out_display_next = '0;
        for (int i = 0; i < SHOWN_DIGITS; i++)
        begin
            if (i < NUM_DIGITS)
            begin
                out_display_next[CODE_W*i +: CODE_W] = digits_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_RESET;
            column_index_reg <= '0;
            settle_count_reg <= '0;
            row_pointer_reg <= '0;
            wait_release_reg <= 1'b0;
            digits_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                settle_ticks_reg <= cfg.settle_ticks;
            end
            if (sample_xfer)
            begin
                column_index_reg <= column_index_next;
                settle_count_reg <= settle_count_next;
                row_pointer_reg <= row_pointer_next;
                wait_release_reg <= wait_release_next;
                digits_reg <= digits_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; only meaningful while out_valid_reg is set.
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            out_column_reg <= out_column_next;
            out_display_reg <= out_display_next;
            out_event_reg <= out_event_next;
            out_code_reg <= out_code_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.column_drive = out_column_reg;
    assign results.display_digits = out_display_reg;
    assign results.key_event = out_event_reg;
    assign results.key_code = out_code_reg;

`ifndef SYNTHESIS
    a_event_holds_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg && $past(sample_xfer)) |-> wait_release_reg)
        else $error("key event without the row being held");

    a_settle_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_xfer && settling) |=> !out_event_reg)
        else $error("key event during settling");

    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(~out_column_reg))
        else $error("column drive not exactly one low");

    a_code_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_event_reg) |-> (out_code_reg == '0))
        else $error("nonzero key code without event");

    a_hold_row: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_xfer && wait_release_reg && pressed) |=> $stable(row_pointer_reg))
        else $error("row moved while a key is held");
`endif

endmodule

// File: tb/keypad_scan_digit_entry_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the keypad scanner with digit entry.
// A scan predictor mirrors the block tick by tick. Every accepted row sample
// pushes one expected result, and every result transfer is checked against
// the oldest expected result.
module keypad_scan_digit_entry_core_tb;

    import kpsd_pkg::*;

    // One result of the scanner, packed at the block's own widths.
    typedef struct packed {
        logic [LINES-1:0]     col_drive;
        logic [DISPLAY_W-1:0] display;
        logic                 evt;
        key_code_t            code;
    } scan_result_t;

    // A line of the directed table is either a row sample or a write of the
    // settle time register.
    typedef enum logic {
        STEP_SAMPLE,
        STEP_SETTLE
    } step_kind_t;

    typedef struct packed {
        step_kind_t   kind;
        logic [15:0]  value;
        logic         typed;
        scan_result_t res;
    } dir_step_t;

    localparam scan_result_t NO_RES = '0;

    // Rows are given as the raw row lines, where a zero bit is a pressed key.
    // The typed results are the ones that follow straight from reset, or that
    // hold the clear code. Settle time is zero from the third line on, so the
    // scan never pauses after a column change in this part.
    localparam int DIR_LEN = 25;
    localparam dir_step_t DIRECTED [0:DIR_LEN-1] = '{
        // Reset state: column 0 driven, display blank, still settling.
        '{STEP_SAMPLE, 16'hF, 1'b1, '{4'b1110, 16'h0000, 1'b0, 4'd0}},
        // All rows low while settling must be ignored.
        '{STEP_SAMPLE, 16'h0, 1'b1, '{4'b1110, 16'h0000, 1'b0, 4'd0}},
        '{STEP_SETTLE, 16'd0, 1'b0, NO_RES},
        // Column 0, row 0 is a clear key.
        '{STEP_SAMPLE, 16'hE, 1'b1, '{4'b1110, 16'h0000, 1'b1, KEY_CLEAR}},
        '{STEP_SAMPLE, 16'hE, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        // Column 1: rows 1 to 3 give 3, 6 and 9.
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hD, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        // Every row low, yet only row 2 is looked at.
        '{STEP_SAMPLE, 16'h0, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hB, 1'b0, NO_RES},
        // Release tick with row 3 already low: row 3 is not sampled here.
        '{STEP_SAMPLE, 16'h4, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'h7, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        // Column 2: row 0 gives 0 and row 3 gives 8.
        '{STEP_SAMPLE, 16'hE, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'h7, 1'b0, NO_RES},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES},
        // Column 3, row 0 clears all four digits.
        '{STEP_SAMPLE, 16'hE, 1'b1, '{4'b0111, 16'h0000, 1'b1, KEY_CLEAR}},
        '{STEP_SAMPLE, 16'hF, 1'b0, NO_RES}
    };

    // Random phases: settle time and the number of samples to send under it,
    // settle ticks included. The last phase picks a small settle time.
    localparam int PHASES = 7;
    localparam logic [15:0] PHASE_SETTLE [0:PHASES-1] =
        '{16'd1, 16'd0, 16'd2, 16'd65535, 16'd3, SETTLE_RESET, 16'd1};
    localparam int PHASE_ROWS [0:PHASES-1] = '{200, 200, 150, 6, 100, 60, 140};

    // Key map by column, then row.
    localparam key_code_t KEYPAD_MAP [0:3][0:3] = '{
        '{KEY_CLEAR, KEY_CLEAR, KEY_CLEAR, KEY_CLEAR},
        '{KEY_CLEAR, 4'd3, 4'd6, 4'd9},
        '{4'd0, 4'd2, 4'd5, 4'd8},
        '{KEY_CLEAR, 4'd1, 4'd4, 4'd7}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kpsd_in_if  samples ();
    kpsd_out_if results ();
    kpsd_cfg_if cfg ();

    keypad_scan_digit_entry_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    always #4 clk = ~clk;

    // Scan predictor state, starting at its reset values.
    logic [15:0]      scan_settle = SETTLE_RESET;
    logic [COL_W-1:0] scan_col = '0;
    logic [15:0]      scan_cnt = '0;
    logic [ROW_W-1:0] scan_row = '0;
    logic             scan_hold = 1'b0;
    digit_array_t     scan_digits = '0;

    scan_result_t expected_q [$];
    int err_count = 0;
    int burst_left = 8;

    // Move to the next row; after row 3 the next column is driven and the
    // settle count restarts.
    task automatic advance_row();
        if (scan_row == ROW_W'(3))
        begin
            scan_row = '0;
            scan_col = scan_col + 1'b1;
            scan_cnt = '0;
        end
        else
        begin
            scan_row = scan_row + 1'b1;
        end
    endtask

    // One tick of the scanner. The outputs reflect the state after the update.
    task automatic scan_step(input logic [3:0] rows, output scan_result_t res);
        key_code_t k;
        res = '0;
        if (scan_cnt < scan_settle)
        begin
            scan_cnt = scan_cnt + 1'b1;
        end
        else if (scan_hold)
        begin
            if (rows[scan_row])
            begin
                scan_hold = 1'b0;
                advance_row();
            end
        end
        else if (!rows[scan_row])
        begin
            k = KEYPAD_MAP[scan_col][scan_row];
            if (k == KEY_CLEAR)
            begin
                scan_digits = '0;
            end
            else
            begin
                for (int i = NUM_DIGITS - 1; i > 0; i--)
                    scan_digits[i] = scan_digits[i-1];
                scan_digits[0] = k;
            end
            res.evt = 1'b1;
            res.code = k;
            scan_hold = 1'b1;
        end
        else
        begin
            advance_row();
        end
        res.col_drive = ~(LINES'(1) << scan_col);
        for (int i = 0; i < NUM_DIGITS && i < SHOWN_DIGITS; i++)
            res.display[CODE_W*i +: CODE_W] = scan_digits[i];
    endtask

    // Random row lines. Most samples follow the scan: the row under test is
    // pressed now and then and held for a few ticks before release, while the
    // other rows carry random levels. The rest is plain noise.
    function automatic logic [3:0] pick_rows();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 2 || scan_cnt < scan_settle)
            return v;
        if (scan_hold)
            v[scan_row] = ($urandom_range(0, 2) == 0);
        else
            v[scan_row] = ($urandom_range(0, 99) >= 35);
        return v;
    endfunction

    // Offer one sample and wait for its transfer. The predictor runs at the
    // transfer, so its state always matches the samples the block has taken.
    // The sender works in bursts; valid only drops at the end of a burst.
    task automatic send_sample(input logic [3:0] rows, input logic typed,
                               input scan_result_t typed_res);
        scan_result_t res;
        samples.valid <= 1'b1;
        samples.row_levels <= rows;
        do
            @(posedge clk);
        while (!samples.ready);
        scan_step(rows, res);
        expected_q.push_back(typed ? typed_res : res);
        if (burst_left == 0)
        begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Stop offering samples and wait until every expected result has come
    // out. Each sample yields exactly one result, so the block is then idle.
    task automatic drain_results();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the settle time register with the block idle.
    task automatic write_settle(input logic [15:0] ticks);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.settle_ticks <= ticks;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        scan_settle = ticks;
    endtask

    // Result checker: every result transfer must match the oldest expected
    // result, field by field.
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no sample outstanding");
                err_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (results.column_drive !== want.col_drive)
                begin
                    $error("column_drive: expected %h, got %h",
                           want.col_drive, results.column_drive);
                    err_count++;
                end
                if (results.display_digits !== want.display)
                begin
                    $error("display_digits: expected %h, got %h",
                           want.display, results.display_digits);
                    err_count++;
                end
                if (results.key_event !== want.evt)
                begin
                    $error("key_event: expected %b, got %b",
                           want.evt, results.key_event);
                    err_count++;
                end
                if (results.key_code !== want.code)
                begin
                    $error("key_code: expected %0d, got %0d",
                           want.code, results.key_code);
                    err_count++;
                end
            end
        end
    end

    // Receiver: runs of constant ready, light and heavy random stalls, and
    // now and then a long hold-off so the output register fills and the
    // block stops taking samples while the sender keeps offering.
    initial
    begin
        int seg;
        int mode;
        int len;
        seg = 0;
        results.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            seg++;
            if (seg % 40 == 3)
            begin
                results.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len = $urandom_range(10, 80);
                repeat (len)
                begin
                    case (mode)
                        0: results.ready <= 1'b1;
                        1: results.ready <= ($urandom_range(0, 3) != 0);
                        default: results.ready <= ($urandom_range(0, 1) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Main sequence: reset, the directed table, then the random phases.
    initial
    begin
        int taken;
        logic [15:0] ticks;
        samples.valid <= 1'b0;
        samples.row_levels <= 4'hF;
        cfg.valid <= 1'b0;
        cfg.settle_ticks <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIR_LEN; n++)
        begin
            if (DIRECTED[n].kind == STEP_SETTLE)
                write_settle(DIRECTED[n].value);
            else
                send_sample(DIRECTED[n].value[3:0], DIRECTED[n].typed, DIRECTED[n].res);
        end

        // Every sample sent counts toward a phase, settle ticks included, so
        // a long settle time only ever shows its first few ticks.
        for (int p = 0; p < PHASES; p++)
        begin
            ticks = (p == PHASES - 1) ? 16'($urandom_range(1, 5)) : PHASE_SETTLE[p];
            write_settle(ticks);
            taken = 0;
            while (taken < PHASE_ROWS[p])
            begin
                taken++;
                send_sample(pick_rows(), 1'b0, NO_RES);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("** keypad_scan_digit_entry_core: PASSED **");
        else
            $display("** keypad_scan_digit_entry_core: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #12_000_000;
        $display("** keypad_scan_digit_entry_core: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/kpsd_pkg.sv
rtl/kpsd_if.sv
rtl/keypad_scan_digit_entry_core.sv
tb/keypad_scan_digit_entry_core_tb.sv
